FILE: rtl/kedrm_pkg.sv
package kedrm_pkg;

    localparam int KEY_W       = 8;
    localparam int ROT_W       = 2;
    localparam int TICK_W      = 15;
    localparam int COMMIT_W    = 10;
    localparam int DBC_W       = 4;
    localparam int ROW_W       = 4;
    localparam int COL_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 15;

    localparam logic [DBC_W-1:0]    DEBOUNCE_TICKS       = 4'd3;
    localparam logic [COMMIT_W-1:0] COMMIT_TIMEOUT_TICKS = 10'd1000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STAR       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_INC    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_DEC    = 3'd5;

    localparam logic [TICK_W-1:0] LONG_PRESS_RST = 15'd500;
    localparam logic [TICK_W-1:0] REPEAT_RST     = 15'd100;
    localparam logic [KEY_W-1:0]  STAR_RST       = 8'd42;
    localparam logic [KEY_W-1:0]  ROT_INC_RST    = 8'd1;
    localparam logic [KEY_W-1:0]  ROT_DEC_RST    = 8'd2;

    localparam logic [KEY_W-1:0] DIGIT_0 = 8'h30;
    localparam logic [KEY_W-1:0] DIGIT_9 = 8'h39;
    localparam logic [ROW_W-1:0] STAR_ROW = 4'd11;
    localparam logic [COL_W-1:0] COL_UNSTARTED = 6'h3f;

    typedef logic [7:0] tap_line_t [32];

    localparam tap_line_t TAP_R1 = '{0: 8'h30, 1: 8'h20, default: 8'h00};
    localparam tap_line_t TAP_R2 = '{
        0: 8'h31, 1: 8'h2e, 2: 8'h21, 3: 8'h2c, 4: 8'h40, 5: 8'h2d, 6: 8'h3a, 7: 8'h3f,
        8: 8'h28, 9: 8'h29, 10: 8'h7e, 11: 8'h2f, 12: 8'h5b, 13: 8'h5d, 14: 8'h23,
        15: 8'h3c, 16: 8'h3e, 17: 8'h3d, 18: 8'h2a, 19: 8'h2b, 20: 8'h24, 21: 8'h25,
        22: 8'h27, 23: 8'h60, 24: 8'h26, 25: 8'h7c, 26: 8'h5f, 27: 8'h5e, 28: 8'h7b,
        29: 8'h7d, default: 8'h00};
    localparam tap_line_t TAP_R3 = '{
        0: 8'he0, 1: 8'he1, 2: 8'he2, 3: 8'he3, 4: 8'hc0, 5: 8'hc1, 6: 8'hc2, 7: 8'hc3,
        8: 8'h32, 9: 8'h61, 10: 8'h62, 11: 8'h63, 12: 8'h41, 13: 8'h42, 14: 8'h43,
        default: 8'h00};
    localparam tap_line_t TAP_R4 = '{
        0: 8'he4, 1: 8'he5, 2: 8'he6, 3: 8'he7, 4: 8'hc4, 5: 8'hc5, 6: 8'hc6, 7: 8'hc7,
        8: 8'h33, 9: 8'h64, 10: 8'h65, 11: 8'h66, 12: 8'h44, 13: 8'h45, 14: 8'h46,
        default: 8'h00};
    localparam tap_line_t TAP_R5 = '{
        0: 8'he8, 1: 8'he9, 2: 8'hea, 3: 8'heb, 4: 8'hc8, 5: 8'hc9, 6: 8'hca, 7: 8'hcb,
        8: 8'h34, 9: 8'h67, 10: 8'h68, 11: 8'h69, 12: 8'h47, 13: 8'h48, 14: 8'h49,
        default: 8'h00};
    localparam tap_line_t TAP_R6 = '{
        0: 8'hec, 1: 8'hed, 2: 8'hee, 3: 8'hef, 4: 8'hcc, 5: 8'hcd, 6: 8'hce, 7: 8'hcf,
        8: 8'h35, 9: 8'h6a, 10: 8'h6b, 11: 8'h6c, 12: 8'h4a, 13: 8'h4b, 14: 8'h4c,
        default: 8'h00};
    localparam tap_line_t TAP_R7 = '{
        0: 8'hf0, 1: 8'hf1, 2: 8'hf2, 3: 8'hf3, 4: 8'hd0, 5: 8'hd1, 6: 8'hd2, 7: 8'hd3,
        8: 8'h36, 9: 8'h6d, 10: 8'h6e, 11: 8'h6f, 12: 8'h4d, 13: 8'h4e, 14: 8'h4f,
        default: 8'h00};
    localparam tap_line_t TAP_R8 = '{
        0: 8'hf4, 1: 8'hf5, 2: 8'hf6, 3: 8'hf7, 4: 8'hd4, 5: 8'hd5, 6: 8'hd6, 7: 8'hd7,
        8: 8'h37, 9: 8'h70, 10: 8'h71, 11: 8'h72, 12: 8'h73, 13: 8'h50, 14: 8'h51,
        15: 8'h52, 16: 8'h53, default: 8'h00};
    localparam tap_line_t TAP_R9 = '{
        0: 8'hf8, 1: 8'hf9, 2: 8'hfa, 3: 8'hfb, 4: 8'hd8, 5: 8'hd9, 6: 8'hda, 7: 8'hdb,
        8: 8'h38, 9: 8'h74, 10: 8'h75, 11: 8'h76, 12: 8'h54, 13: 8'h55, 14: 8'h56,
        default: 8'h00};
    localparam tap_line_t TAP_R10 = '{
        0: 8'hfc, 1: 8'hfd, 2: 8'hfe, 3: 8'hff, 4: 8'hdc, 5: 8'hdd, 6: 8'hde, 7: 8'hdf,
        8: 8'h39, 9: 8'h77, 10: 8'h78, 11: 8'h79, 12: 8'h7a, 13: 8'h57, 14: 8'h58,
        15: 8'h59, 16: 8'h5a, default: 8'h00};
    localparam tap_line_t TAP_R11 = '{0: 8'h2a, default: 8'h00};

    // row 0 means no row; columns past the row end read 0
    function automatic logic [7:0] char_byte(input logic [ROW_W-1:0] row,
                                             input logic [COL_W-1:0] col);
        logic [7:0] b;
        b = 8'h00;
        if (!col[COL_W-1])
        begin
            case (row)
                4'd1:    b = TAP_R1[col[COL_W-2:0]];
                4'd2:    b = TAP_R2[col[COL_W-2:0]];
                4'd3:    b = TAP_R3[col[COL_W-2:0]];
                4'd4:    b = TAP_R4[col[COL_W-2:0]];
                4'd5:    b = TAP_R5[col[COL_W-2:0]];
                4'd6:    b = TAP_R6[col[COL_W-2:0]];
                4'd7:    b = TAP_R7[col[COL_W-2:0]];
                4'd8:    b = TAP_R8[col[COL_W-2:0]];
                4'd9:    b = TAP_R9[col[COL_W-2:0]];
                4'd10:   b = TAP_R10[col[COL_W-2:0]];
                4'd11:   b = TAP_R11[col[COL_W-2:0]];
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

FILE: rtl/kedrm_if.sv
interface kedrm_in_if;
    logic                              valid;
    logic                              ready;
    logic [kedrm_pkg::KEY_W-1:0]        key_code;
    logic signed [kedrm_pkg::ROT_W-1:0] rotary_step;
    logic                              is_nav_key;

    modport source (output valid, key_code, rotary_step, is_nav_key, input ready);
    modport sink (input valid, key_code, rotary_step, is_nav_key, output ready);
endinterface

interface kedrm_out_if;
    logic                       valid;
    logic                       ready;
    logic                       event_valid;
    logic [kedrm_pkg::KEY_W-1:0] out_key;
    logic                       mod_press;
    logic                       mod_down;
    logic                       mod_up;
    logic                       mod_long;
    logic                       mod_preview;

    modport source (output valid, event_valid, out_key, mod_press, mod_down, mod_up,
                    mod_long, mod_preview, input ready);
    modport sink (input valid, event_valid, out_key, mod_press, mod_down, mod_up,
                  mod_long, mod_preview, output ready);
endinterface

FILE: rtl/key_event_debounce_repeat_multitap.sv
// channel   dir  payload                                          transaction
// in_ch     in   key_code, rotary_step, is_nav_key                 valid & ready
// out_ch    out  event_valid, out_key, mod_press/down/up/long/prev valid & ready
// cfg       in   cfg_index, cfg_data                              cfg_we
//
// One poll tick enters an input register, passes one combinational step and lands
// in the result register: one transaction per cycle while the output is not stalled.
// Reset clears engine state and valid flags and loads the register defaults.
// A stalled output holds its result; an empty input register still takes one more tick.
module key_event_debounce_repeat_multitap
#(
    parameter logic [kedrm_pkg::DBC_W-1:0]    DEBOUNCE_TICKS =
        kedrm_pkg::DEBOUNCE_TICKS,
    parameter logic [kedrm_pkg::COMMIT_W-1:0] COMMIT_TIMEOUT_TICKS =
        kedrm_pkg::COMMIT_TIMEOUT_TICKS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    kedrm_in_if.sink                            in_ch,
    kedrm_out_if.source                         out_ch,
    input  logic                                cfg_we,
    input  logic [kedrm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kedrm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DEBOUNCE = 3'd1;
    localparam logic [2:0] ST_PRESS    = 3'd2;
    localparam logic [2:0] ST_WAITLONG = 3'd3;
    localparam logic [2:0] ST_REPEAT   = 3'd4;
    localparam logic [2:0] ST_WAITREL  = 3'd5;

    typedef struct packed {
        logic                         ev;
        logic [kedrm_pkg::KEY_W-1:0]  key;
        logic                         press;
        logic                         down;
        logic                         up;
        logic                         lng;
        logic                         preview;
    } result_t;

    // configuration
    logic [kedrm_pkg::TICK_W-1:0] long_press_reg;
    logic [kedrm_pkg::TICK_W-1:0] repeat_reg;
    logic                         alpha_reg;
    logic [kedrm_pkg::KEY_W-1:0]  star_reg;
    logic [kedrm_pkg::KEY_W-1:0]  rot_inc_reg;
    logic [kedrm_pkg::KEY_W-1:0]  rot_dec_reg;

    // input stage
    logic                              in_valid_reg;
    logic [kedrm_pkg::KEY_W-1:0]        key_reg;
    logic signed [kedrm_pkg::ROT_W-1:0] rot_reg;
    logic                              nav_reg;

    // engine state
    logic [2:0]                     state_reg, state_next;
    logic [kedrm_pkg::DBC_W-1:0]    dbc_count_reg, dbc_count_next;
    logic [kedrm_pkg::KEY_W-1:0]    dbc_key_reg, dbc_key_next;
    logic [kedrm_pkg::KEY_W-1:0]    held_key_reg, held_key_next;
    logic [kedrm_pkg::TICK_W-1:0]   hold_timer_reg, hold_timer_next;
    logic [kedrm_pkg::COMMIT_W-1:0] commit_timer_reg, commit_timer_next;
    logic [kedrm_pkg::ROW_W-1:0]    tap_row_reg, tap_row_next;
    logic [kedrm_pkg::COL_W-1:0]    tap_col_reg, tap_col_next;

    // result stage
    logic    out_valid_reg;
    result_t res_reg, res_next;

    logic res_free;
    logic advance;

    logic [kedrm_pkg::TICK_W-1:0]   hold_dec;
    logic [kedrm_pkg::COMMIT_W-1:0] commit_dec;
    logic [kedrm_pkg::ROW_W-1:0]    nrow;
    logic [kedrm_pkg::COL_W-1:0]    col_inc;
    logic [7:0]                     b_cur;
    logic [7:0]                     b_inc;
    logic [7:0]                     b_row0;
    logic [7:0]                     b_first;
    logic [kedrm_pkg::KEY_W-1:0]    digit_off;

    assign res_free    = !out_valid_reg || out_ch.ready;
    assign advance     = in_valid_reg && res_free;
    assign in_ch.ready = !in_valid_reg || res_free;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.event_valid = res_reg.ev;
    assign out_ch.out_key     = res_reg.key;
    assign out_ch.mod_press   = res_reg.press;
    assign out_ch.mod_down    = res_reg.down;
    assign out_ch.mod_up      = res_reg.up;
    assign out_ch.mod_long    = res_reg.lng;
    assign out_ch.mod_preview = res_reg.preview;

    assign hold_dec   = (hold_timer_reg != '0) ? hold_timer_reg - 1'b1 : hold_timer_reg;
    assign commit_dec = (commit_timer_reg != '0) ? commit_timer_reg - 1'b1 : commit_timer_reg;

    assign digit_off = key_reg - kedrm_pkg::DIGIT_0;
    always_comb
    begin
        if (key_reg >= kedrm_pkg::DIGIT_0 && key_reg <= kedrm_pkg::DIGIT_9)
        begin
            nrow = digit_off[kedrm_pkg::ROW_W-1:0] + 1'b1;
        end
        else if (key_reg == star_reg)
        begin
            nrow = kedrm_pkg::STAR_ROW;
        end
        else
        begin
            nrow = '0;
        end
    end

    assign col_inc = tap_col_reg + 1'b1;
    assign b_cur   = kedrm_pkg::char_byte(tap_row_reg, tap_col_reg);
    assign b_inc   = kedrm_pkg::char_byte(tap_row_reg, col_inc);
    assign b_row0  = kedrm_pkg::char_byte(tap_row_reg, '0);
    assign b_first = kedrm_pkg::char_byte(nrow, '0);

    always_comb
    begin
        state_next        = state_reg;
        dbc_count_next    = dbc_count_reg;
        dbc_key_next      = dbc_key_reg;
        held_key_next     = held_key_reg;
        hold_timer_next   = hold_dec;
        commit_timer_next = commit_dec;
        tap_row_next      = tap_row_reg;
        tap_col_next      = tap_col_reg;
        res_next          = '0;

        if (rot_reg != '0)
        begin
            res_next.ev    = 1'b1;
            res_next.key   = (rot_reg == 2'sd1) ? rot_inc_reg : rot_dec_reg;
            res_next.press = 1'b1;
            res_next.up    = 1'b1;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (key_reg != '0)
                    begin
                        state_next     = ST_DEBOUNCE;
                        dbc_count_next = '0;
                        dbc_key_next   = key_reg;
                        held_key_next  = '0;
                    end
                    if (commit_dec == '0 && tap_row_reg != '0)
                    begin
                        res_next.ev    = 1'b1;
                        res_next.key   = b_cur;
                        res_next.press = 1'b1;
                        tap_row_next   = '0;
                    end
                end
                ST_DEBOUNCE:
                begin
                    if (dbc_count_reg >= DEBOUNCE_TICKS)
                    begin
                        if (dbc_key_reg == key_reg)
                        begin
                            held_key_next = key_reg;
                            state_next    = ST_PRESS;
                        end
                        else
                        begin
                            state_next = ST_WAITREL;
                        end
                    end
                    else
                    begin
                        dbc_count_next = dbc_count_reg + 1'b1;
                    end
                end
                ST_PRESS:
                begin
                    res_next.ev       = 1'b1;
                    res_next.key      = key_reg;
                    res_next.press    = 1'b1;
                    res_next.down     = 1'b1;
                    hold_timer_next   = long_press_reg;
                    commit_timer_next = COMMIT_TIMEOUT_TICKS;
                    state_next        = ST_WAITLONG;
                    if (alpha_reg)
                    begin
                        if (tap_row_reg == '0)
                        begin
                            if (nrow != '0)
                            begin
                                // first tap of a row: preview column 0
                                tap_row_next     = nrow;
                                tap_col_next     = '0;
                                res_next         = '0;
                                res_next.ev      = 1'b1;
                                res_next.key     = b_first;
                                res_next.preview = 1'b1;
                            end
                        end
                        else if (nrow == tap_row_reg)
                        begin
                            // same key again: next column, wrap at row end
                            tap_col_next     = (b_inc == '0) ? '0 : col_inc;
                            res_next         = '0;
                            res_next.ev      = 1'b1;
                            res_next.key     = (b_inc == '0) ? b_row0 : b_inc;
                            res_next.preview = 1'b1;
                        end
                        else
                        begin
                            // other key: commit pending char, redo this press
                            res_next       = '0;
                            res_next.ev    = 1'b1;
                            res_next.key   = b_cur;
                            res_next.press = 1'b1;
                            tap_row_next   = nrow;
                            tap_col_next   = kedrm_pkg::COL_UNSTARTED;
                            state_next     = ST_PRESS;
                        end
                    end
                end
                ST_WAITLONG:
                begin
                    if (key_reg == '0)
                    begin
                        res_next.ev  = 1'b1;
                        res_next.key = held_key_reg;
                        res_next.up  = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else if (hold_dec == '0)
                    begin
                        hold_timer_next = repeat_reg;
                        res_next.ev     = 1'b1;
                        res_next.key    = key_reg;
                        res_next.down   = 1'b1;
                        res_next.lng    = 1'b1;
                        state_next      = ST_REPEAT;
                    end
                end
                ST_REPEAT:
                begin
                    if (key_reg == '0)
                    begin
                        res_next.ev  = 1'b1;
                        res_next.key = held_key_reg;
                        res_next.up  = 1'b1;
                        res_next.lng = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        res_next.ev  = 1'b1;
                        res_next.key = key_reg;
                        res_next.lng = 1'b1;
                        if (hold_dec == '0)
                        begin
                            hold_timer_next = repeat_reg;
                            res_next.press  = nav_reg;
                        end
                    end
                end
                default:
                begin
                    // wait for release
                    if (key_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= kedrm_pkg::LONG_PRESS_RST;
            repeat_reg     <= kedrm_pkg::REPEAT_RST;
            alpha_reg      <= 1'b0;
            star_reg       <= kedrm_pkg::STAR_RST;
            rot_inc_reg    <= kedrm_pkg::ROT_INC_RST;
            rot_dec_reg    <= kedrm_pkg::ROT_DEC_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kedrm_pkg::REG_LONG_PRESS: long_press_reg <= cfg_data;
                kedrm_pkg::REG_REPEAT:     repeat_reg     <= cfg_data;
                kedrm_pkg::REG_ALPHA:      alpha_reg      <= cfg_data[0];
                kedrm_pkg::REG_STAR:       star_reg       <= cfg_data[kedrm_pkg::KEY_W-1:0];
                kedrm_pkg::REG_ROT_INC:    rot_inc_reg    <= cfg_data[kedrm_pkg::KEY_W-1:0];
                kedrm_pkg::REG_ROT_DEC:    rot_dec_reg    <= cfg_data[kedrm_pkg::KEY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            key_reg <= in_ch.key_code;
            rot_reg <= in_ch.rotary_step;
            nav_reg <= in_ch.is_nav_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            dbc_count_reg    <= '0;
            dbc_key_reg      <= '0;
            held_key_reg     <= '0;
            hold_timer_reg   <= '0;
            commit_timer_reg <= '0;
            tap_row_reg      <= '0;
            tap_col_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg        <= state_next;
                dbc_count_reg    <= dbc_count_next;
                dbc_key_reg      <= dbc_key_next;
                held_key_reg     <= held_key_next;
                hold_timer_reg   <= hold_timer_next;
                commit_timer_reg <= commit_timer_next;
                tap_row_reg      <= tap_row_next;
                tap_col_reg      <= tap_col_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

endmodule
